// ----- rtl/mldc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the message loss / duplicate checker.
// Holds field widths, status and register codes, and the word types. No dependencies.
package mldc_pkg;

  localparam int SEQ_W  = 10;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 11;
  localparam int LEN_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Sequence numbers the input field can carry.
  localparam int SEQ_SPACE = 1 << SEQ_W;
  localparam int MAX_MESSAGES_DEF = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN = 1'b1;

  localparam logic [CNT_W-1:0] EXPECTED_RST    = 11'd1024;
  localparam logic [LEN_W-1:0] PAYLOAD_LEN_RST = 16'd256;

  // Message status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_DAMAGED = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_num;
    logic [DATA_W-1:0] data_byte;
    logic              end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [SEQ_W-1:0] msg_seq;
    logic [1:0]       msg_status;
    logic             session_done;
    logic [CNT_W-1:0] lost_total;
    logic [CNT_W-1:0] damaged_total;
    logic [CNT_W-1:0] duplicate_total;
  } out_word_t;

  // End-of-message request from the byte checker to the classifier.
  typedef struct packed {
    logic             valid;
    logic [SEQ_W-1:0] seq;
    logic             ok;
    logic             in_range;
    logic             done;
  } eom_req_t;

  // Classifier status seen by the top level.
  typedef struct packed {
    logic clr_busy;
    logic s1_valid;
  } cls_ctl_t;

endpackage

// ----- rtl/mldc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Read during a write to the same address returns the old contents. No dependencies.
module mldc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mldc_byte_check.sv -----
`timescale 1ns / 1ps
// Byte stage: pattern compare, byte position and session end flag.
// Depends on mldc_pkg.
module mldc_byte_check import mldc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  in_word_t         word,
  input  logic [CNT_W-1:0] size,
  input  logic [LEN_W-1:0] payload_length,
  output eom_req_t         req
);

  logic [LEN_W-1:0] byte_position;
  logic             pattern_ok;
  logic             finished;

  logic [LEN_W-1:0] pos_inc;
  logic             ok_now;
  logic             in_range;
  logic             take;

  always_comb begin
    take     = accept && !finished;
    pos_inc  = (byte_position == {LEN_W{1'b1}}) ? byte_position : byte_position + 1'b1;
    ok_now   = pattern_ok &&
               !((byte_position < payload_length) &&
                 (word.data_byte != byte_position[DATA_W-1:0]));
    in_range = {1'b0, word.seq_num} < size;

    req.valid    = take && word.end_of_message;
    req.seq      = word.seq_num;
    req.ok       = ok_now && !(pos_inc < payload_length);
    req.in_range = in_range;
    req.done     = in_range && (({1'b0, word.seq_num} + 1'b1) == size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pattern_ok    <= 1'b1;
      finished      <= 1'b0;
    end else if (take) begin
      if (word.end_of_message) begin
        byte_position <= '0;
        pattern_ok    <= 1'b1;
        if (req.done) begin
          finished <= 1'b1;
        end
      end else begin
        byte_position <= pos_inc;
        pattern_ok    <= ok_now;
      end
    end
  end

endmodule

// ----- rtl/mldc_classify.sv -----
`timescale 1ns / 1ps
// Classifier: bitmap read-modify-write, session counts and the clearing pass.
// Depends on mldc_pkg and mldc_ram.
module mldc_classify import mldc_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  eom_req_t         req,
  input  logic [CNT_W-1:0] size,
  output cls_ctl_t         ctl,
  output logic             res_valid,
  output out_word_t        res
);

  // Entry bit 0: seen, bit 1: repeat already counted.
  logic          clr_busy;
  logic [AW-1:0] clr_idx;

  logic          s1_valid;
  eom_req_t      s1;

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [1:0]    fwd_data;

  logic [CNT_W-1:0] seen_count, dmg_count, repeat_count;
  logic [CNT_W-1:0] seen_count_next, dmg_count_next, repeat_count_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic [1:0]    wdata;
  logic [1:0]    rd_data;
  logic [1:0]    entry;
  logic [1:0]    new_entry;
  logic [AW-1:0] s1_addr;
  logic [1:0]    status;
  logic          upd;
  logic [CNT_W-1:0] lost;

  mldc_ram #(.WIDTH(2), .DEPTH(DEPTH), .AW(AW)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (req.valid),
    .raddr (req.seq[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    s1_addr = s1.seq[AW-1:0];
    // Forward the write made in the previous cycle; the RAM read missed it.
    entry   = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rd_data;
    upd     = s1_valid && s1.in_range;

    seen_count_next   = seen_count;
    dmg_count_next    = dmg_count;
    repeat_count_next = repeat_count;
    new_entry         = entry;

    if (!s1.in_range) begin
      status = ST_RANGE;
    end else if (entry[0]) begin
      status    = ST_DUP;
      new_entry = 2'b11;
      if (!entry[1]) begin
        repeat_count_next = repeat_count + 1'b1;
      end
    end else begin
      new_entry       = 2'b01;
      seen_count_next = seen_count + 1'b1;
      if (s1.ok) begin
        status = ST_GOOD;
      end else begin
        status         = ST_DAMAGED;
        dmg_count_next = dmg_count + 1'b1;
      end
    end

    lost = (size > seen_count_next) ? size - seen_count_next : '0;

    we    = clr_busy || upd;
    waddr = clr_busy ? clr_idx : s1_addr;
    wdata = clr_busy ? 2'b00 : new_entry;

    res_valid           = s1_valid;
    res.msg_seq         = s1.seq;
    res.msg_status      = status;
    res.session_done    = s1.done;
    res.lost_total      = s1.done ? lost : '0;
    res.damaged_total   = s1.done ? dmg_count_next : '0;
    res.duplicate_total = s1.done ? repeat_count_next : '0;

    ctl.clr_busy = clr_busy;
    ctl.s1_valid = s1_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy     <= 1'b1;
      clr_idx      <= '0;
      s1_valid     <= 1'b0;
      fwd_valid    <= 1'b0;
      seen_count   <= '0;
      dmg_count    <= '0;
      repeat_count <= '0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == AW'(DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      s1_valid  <= req.valid;
      fwd_valid <= upd;
      if (upd) begin
        seen_count   <= seen_count_next;
        dmg_count    <= dmg_count_next;
        repeat_count <= repeat_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1       <= req;
    fwd_addr <= s1_addr;
    fwd_data <= new_entry;
  end

  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !req.valid)
    else $error("message accepted during clearing pass");

  a_totals_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.session_done) |->
      (res.lost_total == '0 && res.damaged_total == '0 && res.duplicate_total == '0))
    else $error("totals shown before session end");

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    seen_count <= CNT_W'(DEPTH))
    else $error("received count above bitmap depth");

endmodule

// ----- rtl/mldc_out_buf.sv -----
`timescale 1ns / 1ps
// Two-entry result buffer between the classifier and the output channel.
// Depends on mldc_pkg.
module mldc_out_buf import mldc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_word_t push_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  output logic [1:0] cnt_after_pop
);

  out_word_t  e0, e1;
  logic [1:0] cnt;
  logic       pop;

  always_comb begin
    pop           = (cnt != 2'd0) && !out_stall;
    out_valid     = (cnt != 2'd0);
    out_word      = e0;
    cnt_after_pop = cnt - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt - {1'b0, pop} + {1'b0, push};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (cnt == 2'd1)) begin
        e0 <= push_word;
      end else begin
        e0 <= e1;
      end
      if (push && (cnt != 2'd1)) begin
        e1 <= push_word;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= push_word;
      end else begin
        e1 <= push_word;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && out_stall) |-> !push)
    else $error("result buffer overflow");

endmodule

// ----- rtl/message_loss_duplicate_checker_core.sv -----
`timescale 1ns / 1ps
// Top level of the message loss / duplicate checker: config registers, flow control.
// Depends on mldc_pkg, mldc_byte_check, mldc_classify, mldc_out_buf.
//
//   channel  dir  handshake            word
//   in       in   in_valid/in_stall    in_word_t: seq_num, data_byte, end_of_message
//   out      out  out_valid/out_stall  out_word_t: status and session totals
//   cfg      in   cfg_write            cfg_index selects register, cfg_data value
//
// One input word per cycle while in_stall is low. A word that ends a message reads the bitmap RAM
// at once; the next cycle classifies it, writes the entry back and pushes the
// result into the result buffer, which registers it and shows it on out.
// After reset a clearing pass writes every bitmap entry, one a cycle
// (min(MAX_MESSAGES, 1024) entries, 1024 by default); in_stall is high meanwhile.
// in_stall also rises when the two-entry result buffer cannot take one more.
module message_loss_duplicate_checker_core import mldc_pkg::*; #(
  parameter int MAX_MESSAGES = MAX_MESSAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Only sequence numbers the field can carry need an entry.
  localparam int DEPTH    = (MAX_MESSAGES < SEQ_SPACE) ? MAX_MESSAGES : SEQ_SPACE;
  localparam int AW       = $clog2(DEPTH);
  localparam int SIZE_CAP = (MAX_MESSAGES < 2047) ? MAX_MESSAGES : 2047;
  localparam logic [CNT_W-1:0] SIZE_CAP_V = CNT_W'(SIZE_CAP);

  logic [CNT_W-1:0] expected_messages;
  logic [LEN_W-1:0] payload_length;
  logic [CNT_W-1:0] size;

  eom_req_t   req;
  cls_ctl_t   ctl;
  logic       res_valid;
  out_word_t  res;
  logic [1:0] cnt_after_pop;
  logic       accept;

  // Hold config registers; they must be written only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_messages <= EXPECTED_RST;
      payload_length    <= PAYLOAD_LEN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXPECTED:    expected_messages <= cfg_data[CNT_W-1:0];
        REG_PAYLOAD_LEN: payload_length    <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Clamp the session size to min(MAX_MESSAGES, 2047).
    size = (expected_messages > SIZE_CAP_V) ? SIZE_CAP_V : expected_messages;
    // Stall when the buffer, after this cycle's pop, plus the word in
    // classification would already fill it.
    in_stall = ctl.clr_busy ||
               (({1'b0, cnt_after_pop} + {2'b00, ctl.s1_valid}) >= 3'd2);
    accept   = in_valid && !in_stall;
  end

  mldc_byte_check u_byte (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .word           (in_word),
    .size           (size),
    .payload_length (payload_length),
    .req            (req)
  );

  mldc_classify #(.DEPTH(DEPTH), .AW(AW)) u_cls (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .size      (size),
    .ctl       (ctl),
    .res_valid (res_valid),
    .res       (res)
  );

  mldc_out_buf u_obuf (
    .clk           (clk),
    .rst           (rst),
    .push          (res_valid),
    .push_word     (res),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cnt_after_pop (cnt_after_pop)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for message_loss_duplicate_checker_core: directed table, then random
// sessions of test messages scored against an in-bench model. Depends on mldc_pkg and the core.
module tb;
  import mldc_pkg::*;

  localparam int unsigned MAX_MSG     = MAX_MESSAGES_DEF;
  localparam int unsigned SETTLE      = 6;     // cycles after the last report before a write
  localparam int unsigned QUIET_LIMIT = 6000;  // covers the bitmap clearing pass with room
  localparam int          N_PLAN      = 23;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  // One row of the directed table: either a register write or one payload word,
  // optionally with the status that word must produce.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       val;
    logic [SEQ_W-1:0]       seq;
    logic [DATA_W-1:0]      data;
    logic                   eom;
    logic                   pinned;
    logic [1:0]             st;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  always #1 clk = ~clk;

  message_loss_duplicate_checker_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Directed table. Payload length is cut to two bytes first so that whole
  // messages fit in a handful of words.
  plan_row_t plan [N_PLAN] = '{
    '{ROW_REG,  REG_PAYLOAD_LEN, 16'd2,      10'd0,    8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd0,    8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd0,    8'd1,   1'b1, 1'b1, ST_GOOD},
    // one byte where two are due
    '{ROW_BYTE, 1'b0,            16'd0,      10'd1,    8'd0,   1'b1, 1'b1, ST_DAMAGED},
    // trailing byte past the payload is ignored
    '{ROW_BYTE, 1'b0,            16'd0,      10'd2,    8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd2,    8'd1,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd2,    8'd255, 1'b1, 1'b1, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd3,    8'd255, 1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd3,    8'd1,   1'b1, 1'b1, ST_DAMAGED},
    // repeats: payload not checked, counted once
    '{ROW_BYTE, 1'b0,            16'd0,      10'd0,    8'd7,   1'b1, 1'b1, ST_DUP},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd0,    8'd0,   1'b1, 1'b1, ST_DUP},
    '{ROW_REG,  REG_EXPECTED,    16'd16,     10'd0,    8'd0,   1'b0, 1'b0, ST_GOOD},
    // only the number on the closing byte counts, even the final one earlier
    '{ROW_BYTE, 1'b0,            16'd0,      10'd15,   8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd1023, 8'd1,   1'b1, 1'b1, ST_RANGE},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd16,   8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd4,    8'd1,   1'b1, 1'b1, ST_GOOD},
    // empty session: everything is out of range
    '{ROW_REG,  REG_EXPECTED,    16'd0,      10'd0,    8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd0,    8'd0,   1'b1, 1'b1, ST_RANGE},
    // size above the bitmap depth clamps; no payload compared at length zero
    '{ROW_REG,  REG_EXPECTED,    16'hFFFF,   10'd0,    8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_REG,  REG_PAYLOAD_LEN, 16'd0,      10'd0,    8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd1022, 8'd171, 1'b1, 1'b1, ST_GOOD},
    '{ROW_REG,  REG_PAYLOAD_LEN, 16'hFFFF,   10'd0,    8'd0,   1'b0, 1'b0, ST_GOOD},
    '{ROW_BYTE, 1'b0,            16'd0,      10'd5,    8'd0,   1'b1, 1'b1, ST_DAMAGED}
  };

  // ---------------------------------------------------------------------------
  // Bench copy of the checker state, kept at reset values until the first write
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] cfg_expected = EXPECTED_RST;
  logic [LEN_W-1:0] cfg_len      = PAYLOAD_LEN_RST;
  bit               rx_seen   [SEQ_SPACE];
  bit               rx_repeat [SEQ_SPACE];
  int unsigned      pos       = 0;
  bit               pat_ok    = 1'b1;
  int unsigned      n_seen    = 0;
  int unsigned      n_damaged = 0;
  int unsigned      n_repeat  = 0;
  bit               closed    = 1'b0;

  out_word_t        due_reports [$];   // status words still owed by the core
  out_word_t        want;
  int unsigned      n_bad      = 0;
  int unsigned      words_sent = 0;
  int unsigned      n_reports  = 0;
  int unsigned      tally [4];
  int unsigned      idle_pct   = 0;
  int unsigned      stall_pct  = 0;
  int unsigned      stall_left = 0;
  int unsigned      quiet      = 0;
  int unsigned      final_sz   = 0;

  function automatic int unsigned eff_size();
    return (cfg_expected > MAX_MSG) ? MAX_MSG : cfg_expected;
  endfunction

  // Advance the model by one payload word; return 1 when it closes a message.
  function automatic bit score_byte(input in_word_t w, output out_word_t r);
    int unsigned sz;
    int unsigned lost;
    bit          last;
    r    = '0;
    last = 1'b0;
    if (closed)
      return 1'b0;
    if (pos < cfg_len && w.data_byte != 8'(pos))
      pat_ok = 1'b0;
    if (pos < 65535)
      pos++;
    if (!w.end_of_message)
      return 1'b0;
    if (pos < cfg_len)
      pat_ok = 1'b0;
    sz = eff_size();
    r.msg_seq = w.seq_num;
    if (w.seq_num >= sz) begin
      r.msg_status = ST_RANGE;
    end else if (rx_seen[w.seq_num]) begin
      r.msg_status = ST_DUP;
      if (!rx_repeat[w.seq_num]) begin
        rx_repeat[w.seq_num] = 1'b1;
        n_repeat++;
      end
    end else begin
      rx_seen[w.seq_num] = 1'b1;
      n_seen++;
      if (pat_ok) begin
        r.msg_status = ST_GOOD;
      end else begin
        r.msg_status = ST_DAMAGED;
        n_damaged++;
      end
    end
    if (w.seq_num < sz && w.seq_num + 1 == sz) begin
      last   = 1'b1;
      closed = 1'b1;
    end
    pos    = 0;
    pat_ok = 1'b1;
    if (last) begin
      lost = (sz > n_seen) ? sz - n_seen : 0;
      r.session_done    = 1'b1;
      r.lost_total      = CNT_W'(lost);
      r.damaged_total   = CNT_W'(n_damaged);
      r.duplicate_total = CNT_W'(n_repeat);
    end
    return 1'b1;
  endfunction

  task automatic flag(input string what);
    if (n_bad < 10)
      $display("tb: mismatch: %s", what);
    n_bad++;
  endtask

  // Present one word, hold it until taken, then score it.
  task automatic push_word(input in_word_t w, output bit got, output out_word_t r);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    got = score_byte(w, r);
    if (got)
      due_reports.push_back(r);
  endtask

  // Write a register once the core has gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_EXPECTED)
      cfg_expected = val[CNT_W-1:0];
    else
      cfg_len = val[LEN_W-1:0];
  endtask

  // Mostly fresh numbers in range, a share of low numbers to force repeats,
  // and the rest out of range when the size leaves room. The final number is never picked here.
  function automatic logic [SEQ_W-1:0] pick_seq();
    int unsigned sz;
    int unsigned r;
    sz = eff_size();
    r  = $urandom_range(0, 99);
    if (sz >= 2 && r < 55)
      return SEQ_W'($urandom_range(0, sz - 2));
    if (sz >= 2 && r < 85)
      return SEQ_W'($urandom_range(0, (sz - 2 < 15) ? sz - 2 : 15));
    if (sz < SEQ_SPACE)
      return SEQ_W'($urandom_range(sz, SEQ_SPACE - 1));
    return SEQ_W'($urandom_range(0, sz - 2));
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cfg_len == 0 || cfg_len > 300)
      return $urandom_range(1, 6);
    if (r < 75)
      return cfg_len;
    if (r < 87 && cfg_len > 1)
      return $urandom_range(1, cfg_len - 1);
    return cfg_len + $urandom_range(1, 3);
  endfunction

  // Send one message carrying the counting pattern; mangle corrupts one byte.
  // Bytes other than the closing one sometimes carry a stray number.
  task automatic send_message(input logic [SEQ_W-1:0] seq, input int unsigned len,
                              input bit mangle);
    in_word_t    w;
    int unsigned bad;
    bit          got;
    out_word_t   r;
    bad = mangle ? $urandom_range(0, len - 1) : len;
    for (int unsigned i = 0; i < len; i++) begin
      w.end_of_message = (i == len - 1);
      w.seq_num   = (w.end_of_message || $urandom_range(0, 3) != 0) ? seq : SEQ_W'($urandom);
      w.data_byte = 8'(i);
      if (i == bad)
        w.data_byte = w.data_byte ^ 8'($urandom_range(1, 255));
      push_word(w, got, r);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] exp_val, input logic [CFG_W-1:0] len_val,
                           input int unsigned budget, input int unsigned pct);
    int unsigned start;
    write_reg(REG_EXPECTED, exp_val);
    write_reg(REG_PAYLOAD_LEN, len_val);
    idle_pct  = pct;
    stall_pct = pct;
    start     = words_sent;
    while (words_sent - start < budget)
      send_message(pick_seq(), pick_len(), $urandom_range(0, 9) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: random bursts of stalled cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Report checker: every taken word is matched against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_reports++;
      if (due_reports.size() == 0) begin
        flag($sformatf("report with none owed: seq %0d status %0d done %0d",
                       out_word.msg_seq, out_word.msg_status, out_word.session_done));
      end else begin
        want = due_reports.pop_front();
        tally[want.msg_status]++;
        if (out_word.msg_seq !== want.msg_seq || out_word.msg_status !== want.msg_status ||
            out_word.session_done !== want.session_done ||
            out_word.lost_total !== want.lost_total ||
            out_word.damaged_total !== want.damaged_total ||
            out_word.duplicate_total !== want.duplicate_total)
          flag($sformatf({"expected seq %0d st %0d done %0d lost %0d dmg %0d dup %0d, ",
                          "got seq %0d st %0d done %0d lost %0d dmg %0d dup %0d"},
                         want.msg_seq, want.msg_status, want.session_done,
                         want.lost_total, want.damaged_total, want.duplicate_total,
                         out_word.msg_seq, out_word.msg_status, out_word.session_done,
                         out_word.lost_total, out_word.damaged_total,
                         out_word.duplicate_total));
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_word_t    w;
    bit          got;
    out_word_t   r;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // hold off until the bitmap clearing pass has finished
    do @(posedge clk); while (in_stall);

    // Directed table, with light idling on both sides
    idle_pct  = 25;
    stall_pct = 25;
    for (int k = 0; k < N_PLAN; k++) begin
      if (plan[k].kind == ROW_REG) begin
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        w.seq_num        = plan[k].seq;
        w.data_byte      = plan[k].data;
        w.end_of_message = plan[k].eom;
        push_word(w, got, r);
        if (plan[k].pinned && (!got || r.msg_status != plan[k].st))
          flag($sformatf("table row %0d: status %0d, table gives %0d",
                         k, r.msg_status, plan[k].st));
      end
    end

    // Random sessions: sizes and lengths over their extremes. The final number
    // of each size is held back so the session stays open until the end.
    run_phase(16'd1024, 16'd4,   140, 20);
    run_phase(16'h0C00, 16'd1,   140, 10);  // upper bits dropped: full size
    run_phase(16'd0,    16'd3,   140, 30);  // nothing in range
    run_phase(16'd1,    16'd2,   140, 15);  // only the final number in range
    run_phase(16'd37,   16'd256, 220, 15);
    run_phase(16'd300,  16'd0,   140, 25);
    run_phase(16'd1000, 16'd8,   140, 0);
    run_phase(16'($urandom_range(2, 1023)), 16'($urandom_range(1, 8)), 140, 20);
    run_phase(16'd1023, 16'd255, 220, 10);
    run_phase(16'd2,    16'd7,   140, 35);

    // Calm tail: no idling on either side from here on.
    idle_pct  = 0;
    stall_pct = 0;

    // Close the session: either a full-size one with losses, or one shrunk
    // below the number already received so the loss total bottoms out.
    final_sz = $urandom_range(0, 1) ? 1024 : $urandom_range(2, 8);
    write_reg(REG_EXPECTED, 16'(final_sz));
    write_reg(REG_PAYLOAD_LEN, 16'd5);
    repeat (12) send_message(pick_seq(), pick_len(), $urandom_range(0, 4) == 0);
    send_message(SEQ_W'(final_sz - 1), 5, 1'b0);

    // After the close: words are taken but produce nothing, writes still land
    repeat (5) send_message(pick_seq(), pick_len(), 1'b0);
    write_reg(REG_PAYLOAD_LEN, 16'd1);
    repeat (5) send_message(pick_seq(), 1, 1'b0);
    in_valid <= 1'b0;

    while (due_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d words in, %0d reports (good %0d, damaged %0d, repeat %0d, range %0d)",
             words_sent, n_reports, tally[ST_GOOD], tally[ST_DAMAGED], tally[ST_DUP],
             tally[ST_RANGE]);
    $display("tb: session closed at size %0d after %0d received, %0d damaged, %0d repeated",
             final_sz, n_seen, n_damaged, n_repeat);
    if (n_bad == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", n_bad);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mldc_pkg.sv
rtl/mldc_ram.sv
rtl/mldc_byte_check.sv
rtl/mldc_classify.sv
rtl/mldc_out_buf.sv
rtl/message_loss_duplicate_checker_core.sv
verif/tb.sv
